@@ rtl/totient_trial_division_assert.svh @@
// ----------------------------------------------------------------------------
// Totient trial division assertion macros
// Concurrent assertion wrappers clocked on i_clk, removed for synthesis.
// ----------------------------------------------------------------------------
`ifndef TOTIENT_TRIAL_DIVISION_ASSERT_SVH
`define TOTIENT_TRIAL_DIVISION_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define TTD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define TTD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define TTD_ASSERT(label, prop, msg)
`define TTD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ rtl/ttd_pkg.sv @@
// ----------------------------------------------------------------------------
// Totient trial division package
// Shared types for the sequencer and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package ttd_pkg;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

`default_nettype wire

@@ rtl/ttd_divider.sv @@
// ----------------------------------------------------------------------------
// Totient trial division shared divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ttd_divider #(
    parameter int WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [WIDTH-1:0]   i_num,
    input  wire logic [WIDTH-1:0]   i_den,
    output logic [WIDTH-1:0]        o_quo,
    output logic [WIDTH-1:0]        o_rem,
    output ttd_pkg::t_div_status    o_stat
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [WIDTH-1:0]   r_quo;
    logic [WIDTH-1:0]   r_rem;
    logic [WIDTH-1:0]   r_den;

    logic [WIDTH:0]     w_shift;
    logic [WIDTH:0]     w_diff;
    logic               w_ge;

    // Bring down the next dividend bit and try to subtract the divisor.
    assign w_shift = {r_rem, r_quo[WIDTH-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (i_start) begin
            r_quo  <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
            r_cnt  <= CNT_W'(WIDTH - 1);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[WIDTH-1:0] : w_shift[WIDTH-1:0];
            r_quo <= {r_quo[WIDTH-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end
    end

    assign o_quo       = r_quo;
    assign o_rem       = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

@@ rtl/totient_trial_division.sv @@
// ----------------------------------------------------------------------------
// Totient trial division
// Euler's totient of one unsigned integer per transaction by trial division.
// ----------------------------------------------------------------------------
// The block takes one VALUE_BITS-bit unsigned value per input transaction and
// returns phi(value) in one output transaction. Candidate divisors d run from
// 2 upward while d*d <= value; d*d is kept as a running square that grows by
// 2d+1 per step, so the bound needs only an adder. All division goes through
// one shared restoring divider that yields one quotient bit per cycle. Each
// candidate costs one division for its divisibility test; each prime factor
// found adds one division of the running result, one division per further
// power of that factor and one more that finds no further power; a leftover
// prime cofactor adds one more division at the end. The input side is ready
// only while the sequencer is idle. The result sits in an output register,
// and the next item may be accepted while it still waits there.
// ----------------------------------------------------------------------------
`default_nettype none

`include "totient_trial_division_assert.svh"

module totient_trial_division #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [VALUE_BITS-1:0]  i_value,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [VALUE_BITS-1:0]       o_totient
);

    localparam int W    = VALUE_BITS;
    // The candidate never passes floor(sqrt(2^W)) + 1.
    localparam int D_W  = W / 2 + 2;
    // The running square never passes value + 2*sqrt(value) + 1.
    localparam int SQ_W = W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WREST,
        S_WACC,
        S_WSTRIP,
        S_FINAL,
        S_WFIN,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [W-1:0]       r_value;
    logic [W-1:0]       r_rest;
    logic [W-1:0]       r_acc;
    logic [D_W-1:0]     r_d;
    logic [SQ_W-1:0]    r_sq;
    logic               r_out_valid;
    logic [W-1:0]       r_totient;
    logic               r_div_start;
    logic [W-1:0]       r_div_num;
    logic [W-1:0]       r_div_den;

    logic [W-1:0]           w_div_quo;
    logic [W-1:0]           w_div_rem;
    ttd_pkg::t_div_status   w_div_stat;
    logic [W-1:0]           w_d_ext;
    logic [SQ_W-1:0]        w_sq_next;

    assign w_d_ext   = {{(W - D_W){1'b0}}, r_d};
    // (d+1)^2 = d^2 + 2d + 1
    assign w_sq_next = r_sq + {{(SQ_W - D_W - 1){1'b0}}, r_d, 1'b1};

    ttd_divider #(
        .WIDTH (W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem),
        .o_stat  (w_div_stat)
    );

    always_ff @(posedge i_clk) begin
        r_div_start <= 1'b0;
        if (r_out_valid && i_ready) begin
            r_out_valid <= 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_value <= i_value;
                    r_rest  <= i_value;
                    r_acc   <= i_value;
                    r_d     <= D_W'(2);
                    r_sq    <= SQ_W'(4);
                    r_state <= S_CHECK;
                end
            end
            S_CHECK: begin
                // Keep trying candidates while d*d does not exceed the input.
                if (r_sq <= {2'b00, r_value}) begin
                    r_div_start <= 1'b1;
                    r_div_num   <= r_rest;
                    r_div_den   <= w_d_ext;
                    r_state     <= S_WREST;
                end else begin
                    r_state <= S_FINAL;
                end
            end
            S_WREST: begin
                if (w_div_stat.done) begin
                    if (w_div_rem == '0) begin
                        // d is a prime factor: scale the result by (d-1)/d,
                        // written as acc - acc/d.
                        r_rest      <= w_div_quo;
                        r_div_start <= 1'b1;
                        r_div_num   <= r_acc;
                        r_div_den   <= w_d_ext;
                        r_state     <= S_WACC;
                    end else begin
                        r_d     <= r_d + 1'b1;
                        r_sq    <= w_sq_next;
                        r_state <= S_CHECK;
                    end
                end
            end
            S_WACC: begin
                if (w_div_stat.done) begin
                    r_acc       <= r_acc - w_div_quo;
                    r_div_start <= 1'b1;
                    r_div_num   <= r_rest;
                    r_div_den   <= w_d_ext;
                    r_state     <= S_WSTRIP;
                end
            end
            S_WSTRIP: begin
                // Divide out every further power of the factor.
                if (w_div_stat.done) begin
                    if (w_div_rem == '0) begin
                        r_rest      <= w_div_quo;
                        r_div_start <= 1'b1;
                        r_div_num   <= w_div_quo;
                        r_div_den   <= w_d_ext;
                    end else begin
                        r_d     <= r_d + 1'b1;
                        r_sq    <= w_sq_next;
                        r_state <= S_CHECK;
                    end
                end
            end
            S_FINAL: begin
                // A cofactor above one left after the search is prime.
                if (r_rest > W'(1)) begin
                    r_div_start <= 1'b1;
                    r_div_num   <= r_acc;
                    r_div_den   <= r_rest;
                    r_state     <= S_WFIN;
                end else begin
                    r_state <= S_DONE;
                end
            end
            S_WFIN: begin
                if (w_div_stat.done) begin
                    r_acc   <= r_acc - w_div_quo;
                    r_state <= S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    r_out_valid <= 1'b1;
                    r_totient   <= r_acc;
                    r_state     <= S_IDLE;
                end
            end
            default: begin
                r_state <= S_IDLE;
            end
        endcase
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_totient = r_totient;

    // An accepted transaction keeps the sequencer busy in the next cycle.
    `TTD_ASSERT(a_busy_after_accept, (i_valid && o_ready) |=> !o_ready, "ready after accept")
    // The totient never exceeds the value it was computed from.
    `TTD_ASSERT(a_acc_bound, (r_state == S_DONE) |-> (r_acc <= r_value), "totient above value")
    // The shared divider is never restarted while it is still working.
    `TTD_ASSERT(a_div_free, r_div_start |-> !w_div_stat.busy, "divider restarted while busy")
    // Reset leaves no result pending.
    `TTD_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// Totient trial division testbench
// Streams integers into the block and checks every returned totient against
// a trial-division predictor, with random idling on both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS = 32;

    // One queued input transaction. A request can ask the sender to wait until
    // every outstanding totient has been returned, and it can ask for no gap
    // after it is taken so that runs of back-to-back transactions occur.
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  drain_first;
        logic                  back_to_back;
    } t_value_req;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [VALUE_BITS-1:0] i_value = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [VALUE_BITS-1:0] o_totient;

    t_value_req            pending_values[$];
    logic [VALUE_BITS-1:0] expected_totients[$];

    // Handshake flags captured at the rising edge and read by the drivers at
    // the following falling edge, so both sides see a settled view.
    logic        in_fire  = 1'b0;
    logic        out_fire = 1'b0;
    int unsigned results_seen = 0;
    int unsigned fail_count   = 0;
    // Result count after which the receiver goes quiet for a long stretch.
    int unsigned hold_at      = 0;

    int unsigned tx_gap  = 0;
    int unsigned rx_gap  = 0;
    int unsigned rx_hold = 0;

    totient_trial_division #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_totient(o_totient)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Euler's totient by trial division. Candidates run while d*d does not
    // exceed the original value, written as d <= n/d so nothing overflows.
    // Every prime factor scales the running count by (p-1)/p, and whatever
    // cofactor survives the loop is a prime of its own.
    function automatic logic [VALUE_BITS-1:0] euler_phi(input logic [VALUE_BITS-1:0] n);
        logic [63:0] rest;
        logic [63:0] count;
        logic [63:0] d;
        rest  = 64'(n);
        count = 64'(n);
        for (d = 64'd2; d <= 64'(n) / d; d++) begin
            if (rest % d == 0) begin
                count = count / d * (d - 1);
                while (rest % d == 0) begin
                    rest = rest / d;
                end
            end
        end
        if (rest > 1) begin
            count = count / rest * (rest - 1);
        end
        return count[VALUE_BITS-1:0];
    endfunction

    task automatic add_value(input logic [VALUE_BITS-1:0] v, input bit drain, input bit burst);
        t_value_req req;
        req.value        = v;
        req.drain_first  = drain;
        req.back_to_back = burst;
        pending_values.push_back(req);
    endtask

    // Random operand. The block's run time grows with the square root of the
    // value, so most operands stay small and only a few reach 20 bits.
    function automatic logic [VALUE_BITS-1:0] random_value();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return VALUE_BITS'($urandom_range(0, 4095));
        end else if (pick < 95) begin
            return VALUE_BITS'($urandom_range(0, 65535));
        end else begin
            return VALUE_BITS'($urandom_range(0, (1 << 20) - 1));
        end
    endfunction

    // Sender. A transaction on offer is held until taken; after that the wait
    // drawn when it was issued runs out before the next one goes up.
    always @(negedge i_clk) begin : sender
        t_value_req head;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap  <= 0;
        end else if (i_valid && !in_fire) begin
            // Still waiting for the block to accept; payload stays put.
        end else if (tx_gap != 0) begin
            i_valid <= 1'b0;
            tx_gap  <= tx_gap - 1;
        end else if (pending_values.size() != 0 &&
                     !(pending_values[0].drain_first && expected_totients.size() != 0)) begin
            head    = pending_values.pop_front();
            i_valid <= 1'b1;
            i_value <= head.value;
            tx_gap  <= head.back_to_back ? 0 : $urandom_range(0, 17);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Receiver. After each result it draws a wait; in every third stretch of
    // ten results it takes them back to back. Once, right after the directed
    // results, it refuses results for a long stretch while the sender keeps
    // offering short transactions, so the output register fills and the
    // block has to push back on its input.
    always @(negedge i_clk) begin : receiver
        int unsigned wait_n;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_gap  <= 0;
            rx_hold <= 0;
        end else if (out_fire && results_seen == hold_at) begin
            i_ready <= 1'b0;
            rx_hold <= 600;
        end else if (rx_hold != 0) begin
            i_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (out_fire) begin
            wait_n  = ((results_seen / 10) % 3 == 0) ? 0 : $urandom_range(0, 17);
            i_ready <= (wait_n == 0);
            rx_gap  <= (wait_n == 0) ? 0 : wait_n - 1;
        end else if (rx_gap != 0) begin
            i_ready <= 1'b0;
            rx_gap  <= rx_gap - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Monitor. A returned result is checked before this edge's accepted input
    // is predicted, so a result can never be matched against its own input.
    always @(posedge i_clk) begin : monitor
        logic [VALUE_BITS-1:0] want;
        in_fire  <= i_rst_n && i_valid && o_ready;
        out_fire <= i_rst_n && o_valid && i_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_totients.size() == 0) begin
                    $error("totient: result %0d returned with nothing outstanding",
                           o_totient);
                    fail_count++;
                end else begin
                    want = expected_totients.pop_front();
                    if (o_totient !== want) begin
                        $error("totient: expected %0d, actual %0d", want, o_totient);
                        fail_count++;
                    end
                end
                results_seen++;
            end
            if (i_valid && o_ready) begin
                expected_totients.push_back(euler_phi(i_value));
            end
        end
    end

    initial begin : stimulus
        bit burst;
        // Directed: zero and one, the first few integers, a perfect square on
        // the loop bound, prime powers, a primorial, a large prime cofactor
        // left after the loop, and the all-ones value.
        add_value(32'd0, 1'b0, 1'b0);
        add_value(32'd1, 1'b0, 1'b0);
        add_value(32'd2, 1'b0, 1'b0);
        add_value(32'd3, 1'b0, 1'b1);
        add_value(32'd4, 1'b0, 1'b1);
        add_value(32'd5, 1'b0, 1'b0);
        add_value(32'd6, 1'b0, 1'b0);
        add_value(32'd7, 1'b0, 1'b0);
        add_value(32'd8, 1'b0, 1'b0);
        add_value(32'd9, 1'b0, 1'b0);
        add_value(32'd12, 1'b0, 1'b0);
        add_value(32'd25, 1'b0, 1'b0);
        add_value(32'd30, 1'b0, 1'b0);
        add_value(32'd49, 1'b0, 1'b0);
        add_value(32'd97, 1'b0, 1'b0);
        add_value(32'd2310, 1'b0, 1'b0);
        add_value(32'd16129, 1'b0, 1'b0);
        add_value(32'd65521, 1'b0, 1'b0);
        add_value(32'd65536, 1'b0, 1'b0);
        add_value(32'd131042, 1'b0, 1'b0);
        add_value(32'd999983, 1'b0, 1'b0);
        add_value(32'd1048576, 1'b0, 1'b0);
        add_value(32'hFFFF_FFFF, 1'b0, 1'b0);
        hold_at = pending_values.size();

        // Pause until the directed results are all back, then offer a run of
        // tiny operands without gaps while the receiver is holding off.
        for (int k = 0; k < 12; k++) begin
            add_value(VALUE_BITS'($urandom_range(0, 15)), k == 0, 1'b1);
        end

        // Random part, in stretches of ten that are either back to back or
        // spaced out, with an occasional pause for a full drain.
        burst = 1'b0;
        for (int k = 0; k < 65; k++) begin
            if (k % 10 == 0) begin
                burst = ($urandom_range(0, 3) == 0);
            end
            add_value(random_value(), $urandom_range(0, 29) == 0, burst);
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_values.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (expected_totients.size() != 0) begin
            @(posedge i_clk);
        end
        // Catch any stray result that shows up after the last expected one.
        repeat (100) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // The all-ones operand has the longest candidate search of all; this
    // leaves ample room above the slowest passing run.
    initial begin : watchdog
        #400ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
